/* src/apr_pkg.sv */
// Package for the attributed parameter register bank: request and response
// types, default tables and per-index attribute functions.
// No dependencies.
package apr_pkg;

    localparam int ENTRY_COUNT   = 64;   // indices at or above this are rejected
    localparam int REQUEST_BYTES = 5;    // largest legal request size, index byte included
    localparam int LISTED_COUNT  = 43;   // entries with a default table row
    localparam int CTRL_FIRST    = 32;
    localparam int CTRL_LAST     = 42;
    localparam int WR_COUNT      = 15;   // writable entries: 3 to 6 and 32 to 42
    localparam int SLOT_W        = $clog2(WR_COUNT);
    localparam int LIST_W        = $clog2(LISTED_COUNT);

    localparam logic [31:0] ONES = 32'hffff_ffff;

    typedef logic [LIST_W-1:0] t_list_idx;
    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } t_cmd;

    typedef struct packed {
        logic        command;
        logic [7:0]  index;
        logic [3:0]  request_size;
        logic [31:0] payload_value;
    } t_req;

    typedef struct packed {
        logic        accepted;
        logic [31:0] read_value;
        logic [2:0]  read_width;
        logic        control_changed;
    } t_rsp;

    localparam logic [31:0] DEF_VALUE [LISTED_COUNT] = '{
        32'h0, 32'h0101_0003, ONES, 32'h0, 32'haa, 32'h0, 32'h0, 32'h0, 32'h0,
        ONES, ONES, ONES, ONES, ONES, ONES, ONES,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES, ONES,
        32'hed, 32'h23, 32'h0, 32'hff, 32'h0, 32'h0, 32'd6,
        32'd100, 32'd100, 32'd100, 32'd100
    };

    localparam logic [2:0] DEF_WIDTH [LISTED_COUNT] = '{
        3'd1, 3'd4, 3'd0, 3'd2, 3'd1, 3'd2, 3'd2, 3'd1, 3'd1,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd2, 3'd4, 3'd2, 3'd2, 3'd2,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
    };

    // entry index held by each writable slot
    localparam logic [7:0] WR_INDEX [WR_COUNT] = '{
        8'd3, 8'd4, 8'd5, 8'd6,
        8'd32, 8'd33, 8'd34, 8'd35, 8'd36, 8'd37,
        8'd38, 8'd39, 8'd40, 8'd41, 8'd42
    };

    function automatic logic is_listed(input logic [7:0] idx);
        return ({1'b0, idx} < 9'(LISTED_COUNT));
    endfunction

    function automatic logic is_writable(input logic [7:0] idx);
        return (idx inside {[8'd3:8'd6], [8'(CTRL_FIRST):8'(CTRL_LAST)]});
    endfunction

    function automatic logic is_ctrl(input logic [7:0] idx);
        return (idx inside {[8'(CTRL_FIRST):8'(CTRL_LAST)]});
    endfunction

    function automatic t_slot slot_of(input logic [7:0] idx);
        logic [7:0] s;
        s = (idx < 8'(CTRL_FIRST)) ? (idx - 8'd3) : (idx - 8'(CTRL_FIRST) + 8'd4);
        return s[SLOT_W-1:0];
    endfunction

    function automatic logic [2:0] width_of(input logic [7:0] idx);
        return is_listed(idx) ? DEF_WIDTH[t_list_idx'(idx[LIST_W-1:0])] : 3'd0;
    endfunction

endpackage

/* src/attributed_parameter_register_bank.sv */
// Attributed parameter register bank: one request per cycle; each result
// passes an input register, then a result register, before it is shown.
// busy is never raised; a request can be taken every cycle.
// o_strobe marks each result for exactly one cycle; the receiver cannot stall.
// Synchronous active-low reset restores every entry to its default and clears
// identity in the same edge; no clearing pass is needed.
module attributed_parameter_register_bank #(
    parameter int ENTRY_COUNT   = apr_pkg::ENTRY_COUNT,
    parameter int REQUEST_BYTES = apr_pkg::REQUEST_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  apr_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    output logic          o_strobe,
    output apr_pkg::t_rsp o_rsp
);

    logic                r_vld;
    apr_pkg::t_req       r_req;
    logic [7:0]          r_identity;
    logic [31:0]         r_entry [apr_pkg::WR_COUNT];
    logic                r_out_vld;
    apr_pkg::t_rsp       r_rsp;

    apr_pkg::t_rsp       n_rsp;
    logic                n_wr;
    logic [31:0]         n_wdata;
    apr_pkg::t_slot      slot;
    logic                in_range;
    logic                size_ok;
    logic [2:0]          ent_width;
    logic [3:0]          pay_width;
    logic [31:0]         stored_val;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= 1'b0;
            r_identity <= 8'd0;
        end else begin
            r_vld <= start && !busy;
            if (i_cfg_we) begin
                r_identity <= i_cfg_data;
            end
        end
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    always_comb begin
        slot      = apr_pkg::slot_of(r_req.index);
        in_range  = ({1'b0, r_req.index} < 9'(ENTRY_COUNT));
        size_ok   = (r_req.request_size != 4'd0)
                 && (r_req.request_size <= 4'(REQUEST_BYTES));
        ent_width = apr_pkg::width_of(r_req.index);
        pay_width = r_req.request_size - 4'd1;

        if (r_req.index == 8'd0) begin
            stored_val = {24'd0, r_identity};
        end else if (apr_pkg::is_writable(r_req.index)) begin
            stored_val = r_entry[slot];
        end else if (apr_pkg::is_listed(r_req.index)) begin
            stored_val = apr_pkg::DEF_VALUE[apr_pkg::t_list_idx'(
                             r_req.index[apr_pkg::LIST_W-1:0])];
        end else begin
            stored_val = apr_pkg::ONES;
        end

        // keep only the payload bytes
        for (int b = 0; b < 4; b++) begin
            n_wdata[8*b +: 8] = (4'(b) < pay_width) ? r_req.payload_value[8*b +: 8] : 8'd0;
        end

        n_rsp = '0;
        n_wr  = 1'b0;
        case (r_req.command)
            apr_pkg::CMD_READ: begin
                if (in_range) begin
                    n_rsp.accepted   = 1'b1;
                    n_rsp.read_value = stored_val;
                    n_rsp.read_width = ent_width;
                end
            end
            apr_pkg::CMD_WRITE: begin
                if (size_ok && in_range && apr_pkg::is_writable(r_req.index)
                    && (pay_width <= {1'b0, ent_width})) begin
                    n_wr                  = r_vld;
                    n_rsp.accepted        = 1'b1;
                    n_rsp.control_changed = apr_pkg::is_ctrl(r_req.index);
                end
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            for (int s = 0; s < apr_pkg::WR_COUNT; s++) begin
                r_entry[s] <= apr_pkg::DEF_VALUE[apr_pkg::t_list_idx'(
                                  apr_pkg::WR_INDEX[s][apr_pkg::LIST_W-1:0])];
            end
        end else begin
            r_out_vld <= r_vld;
            if (n_wr) begin
                r_entry[slot] <= n_wdata;
            end
        end
        r_rsp <= n_rsp;
    end

    assign o_strobe = r_out_vld;
    assign o_rsp    = r_rsp;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("result did not follow request after two cycles");

    a_width_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.read_width != 3'd0) |-> (o_rsp.accepted && o_rsp.read_width <= 3'd4))
        else $error("read width on rejected request or out of range");

    a_ctrl_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_rsp.control_changed)
            |-> (o_rsp.accepted && o_rsp.read_width == 3'd0 && o_rsp.read_value == 32'd0))
        else $error("control change flagged on a read or rejected write");

    a_write_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_wr |-> (r_vld && r_req.command == apr_pkg::CMD_WRITE))
        else $error("entry written without a valid write request");

endmodule

/* tb/sv/attributed_parameter_register_bank_checker.sv */
// Checker for the attributed parameter register bank: watches the request,
// configuration and response channels, predicts each response and compares.
// Depends on apr_pkg for the request and response types.
module attributed_parameter_register_bank_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  apr_pkg::t_req i_req,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_strobe,
    input  apr_pkg::t_rsp i_rsp,
    output int            o_failures,
    output int            o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ROWS = 43;

    localparam logic [31:0] RESET_VALUE [TABLE_ROWS] = '{
        32'h0, 32'h0101_0003, 32'hffff_ffff, 32'h0, 32'haa, 32'h0, 32'h0, 32'h0, 32'h0,
        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
        32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
        32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
        32'hed, 32'h23, 32'h0, 32'hff, 32'h0, 32'h0, 32'd6,
        32'd100, 32'd100, 32'd100, 32'd100
    };

    localparam logic [2:0] BYTE_WIDTH [TABLE_ROWS] = '{
        3'd1, 3'd4, 3'd0, 3'd2, 3'd1, 3'd2, 3'd2, 3'd1, 3'd1,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd2, 3'd4, 3'd2, 3'd2, 3'd2,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1
    };

    localparam bit WRITABLE [TABLE_ROWS] = '{
        1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1
    };

    logic [31:0]   bank [apr_pkg::ENTRY_COUNT];
    logic [7:0]    identity;
    apr_pkg::t_rsp expected_rsp [$];
    apr_pkg::t_rsp oldest;
    int            fail_total = 0;

    function automatic logic [2:0] entry_width(input logic [7:0] idx);
        return (idx < TABLE_ROWS) ? BYTE_WIDTH[idx] : 3'd0;
    endfunction

    function automatic bit entry_writable(input logic [7:0] idx);
        return (idx < TABLE_ROWS) ? WRITABLE[idx] : 1'b0;
    endfunction

    // applies one request to the shadow bank and returns the response it gives
    function automatic apr_pkg::t_rsp apply_request(input apr_pkg::t_req r);
        apr_pkg::t_rsp rsp;
        logic [2:0]    span;
        logic [31:0]   keep;
        rsp = '0;
        if (r.command == apr_pkg::CMD_READ) begin
            if (r.index < apr_pkg::ENTRY_COUNT) begin
                rsp.accepted   = 1'b1;
                rsp.read_value = (r.index == 8'd0) ? {24'h0, identity} : bank[r.index];
                rsp.read_width = entry_width(r.index);
            end
        end else if (r.request_size != 4'd0 && r.request_size <= apr_pkg::REQUEST_BYTES
                     && r.index < apr_pkg::ENTRY_COUNT && entry_writable(r.index)) begin
            span = 3'(r.request_size - 4'd1);
            if (span <= entry_width(r.index)) begin
                keep = (span >= 3'd4) ? 32'hffff_ffff : ((32'h1 << (8 * span)) - 32'h1);
                bank[r.index] = r.payload_value & keep;
                rsp.accepted = 1'b1;
                rsp.control_changed = (r.index >= apr_pkg::CTRL_FIRST
                                       && r.index <= apr_pkg::CTRL_LAST);
            end
        end
        return rsp;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < apr_pkg::ENTRY_COUNT; k++)
                bank[k] = (k < TABLE_ROWS) ? RESET_VALUE[k] : 32'hffff_ffff;
            identity = 8'd0;
            expected_rsp.delete();
        end else begin
            if (i_strobe) begin
                if (expected_rsp.size() == 0) begin
                    $display("%0t: response with no request outstanding, expected none actual %h",
                             $time, i_rsp);
                    fail_total++;
                end else begin
                    oldest = expected_rsp.pop_front();
                    check_field("accepted", 32'(oldest.accepted), 32'(i_rsp.accepted));
                    check_field("read_value", oldest.read_value, i_rsp.read_value);
                    check_field("read_width", 32'(oldest.read_width), 32'(i_rsp.read_width));
                    check_field("control_changed", 32'(oldest.control_changed),
                                32'(i_rsp.control_changed));
                end
            end
            if (i_start && !i_busy)
                expected_rsp.push_back(apply_request(i_req));
            if (i_cfg_we)
                identity = i_cfg_data;
        end
        o_outstanding <= expected_rsp.size();
        o_failures    <= fail_total;
    end

endmodule

/* tb/sv/attributed_parameter_register_bank_test.sv */
// Top of the register bank testbench: clock, reset, directed and random
// requests, identity writes and the verdict.
// Depends on apr_pkg, the bank RTL and attributed_parameter_register_bank_checker.
module attributed_parameter_register_bank_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 190;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [7:0] WRITE_TARGETS [15] = '{
        8'd3, 8'd4, 8'd5, 8'd6, 8'd32, 8'd33, 8'd34, 8'd35,
        8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42
    };

    logic          i_clk;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    apr_pkg::t_req i_req;
    logic          i_cfg_we;
    logic [7:0]    i_cfg_data;
    logic          o_strobe;
    apr_pkg::t_rsp o_rsp;
    int            failures;
    int            outstanding;
    int            cycle_count = 0;
    bit            dense;

    attributed_parameter_register_bank dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_strobe   (o_strobe),
        .o_rsp      (o_rsp)
    );

    attributed_parameter_register_bank_checker checker_inst (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (i_req),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_strobe      (o_strobe),
        .i_rsp         (o_rsp),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic apr_pkg::t_req make_req(input logic cmd, input logic [7:0] idx,
                                               input logic [3:0] size,
                                               input logic [31:0] payload);
        apr_pkg::t_req r;
        r.command       = cmd;
        r.index         = idx;
        r.request_size  = size;
        r.payload_value = payload;
        return r;
    endfunction

    function automatic int idle_cycles();
        int roll;
        if (dense)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // mostly well-formed writes to writable entries and in-range reads
    function automatic apr_pkg::t_req random_request();
        apr_pkg::t_req r;
        logic [7:0]    target;
        target = WRITE_TARGETS[$urandom_range(0, 14)];
        r = make_req(apr_pkg::CMD_READ, 8'($urandom_range(0, 63)),
                     4'($urandom_range(0, 15)), $urandom);
        case ($urandom_range(0, 9))
            0, 1, 2: ;
            3: r.index = 8'($urandom_range(0, 255));
            4, 5, 6, 7: begin
                r.command = apr_pkg::CMD_WRITE;
                r.index = target;
                r.request_size = (target inside {8'd3, 8'd5, 8'd6, 8'd36}) ?
                                 4'($urandom_range(1, 3)) : 4'($urandom_range(1, 2));
            end
            8: begin
                r.command = apr_pkg::CMD_WRITE;
                r.index = target;
            end
            default: begin
                r.command = apr_pkg::CMD_WRITE;
                r.index = 8'($urandom_range(0, 255));
            end
        endcase
        return r;
    endfunction

    // holds start high until the request is taken; busy is sampled mid-cycle
    task automatic send_request(input apr_pkg::t_req r);
        int   gap;
        logic stalled;
        gap = idle_cycles();
        if (gap > 0) begin
            start <= 1'b0;
            i_req <= make_req(1'($urandom), 8'($urandom), 4'($urandom), $urandom);
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do begin
            @(negedge i_clk);
            stalled = busy;
            @(posedge i_clk);
        end while (stalled);
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(negedge i_clk); while (outstanding != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_identity(input logic [7:0] value);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_req      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_data <= 8'd0;
        dense = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_identity(8'h00);
        // range limits, read-only entries, bad sizes, empty and too-wide payloads
        send_request(make_req(apr_pkg::CMD_READ, 8'd0, 4'd0, 32'h0));
        send_request(make_req(apr_pkg::CMD_READ, 8'd1, 4'd15, 32'hffff_ffff));
        send_request(make_req(apr_pkg::CMD_READ, 8'd2, 4'd0, 32'h0));
        send_request(make_req(apr_pkg::CMD_READ, 8'd42, 4'd0, 32'h0));
        send_request(make_req(apr_pkg::CMD_READ, 8'd43, 4'd0, 32'h0));
        send_request(make_req(apr_pkg::CMD_READ, 8'd63, 4'd0, 32'h0));
        send_request(make_req(apr_pkg::CMD_READ, 8'd64, 4'd0, 32'h0));
        send_request(make_req(apr_pkg::CMD_READ, 8'd255, 4'd0, 32'h0));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd3, 4'd1, 32'hffff_ffff));
        send_request(make_req(apr_pkg::CMD_READ, 8'd3, 4'd0, 32'h0));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd3, 4'd3, 32'hffff_ffff));
        send_request(make_req(apr_pkg::CMD_READ, 8'd3, 4'd0, 32'h0));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd4, 4'd3, 32'h1234_5678));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd4, 4'd2, 32'hffff_ffff));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd32, 4'd2, 32'h1234_5678));
        send_request(make_req(apr_pkg::CMD_READ, 8'd32, 4'd0, 32'h0));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd42, 4'd2, 32'h0000_00ff));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd0, 4'd2, 32'h0000_0055));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd2, 4'd1, 32'h0));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd43, 4'd1, 32'h0));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd64, 4'd2, 32'h0));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd255, 4'd2, 32'h0));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd36, 4'd0, 32'hffff_ffff));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd36, 4'd6, 32'hffff_ffff));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd36, 4'd15, 32'hffff_ffff));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd36, 4'd5, 32'hffff_ffff));
        send_request(make_req(apr_pkg::CMD_WRITE, 8'd36, 4'd3, 32'hdead_beef));
        send_request(make_req(apr_pkg::CMD_READ, 8'd36, 4'd0, 32'h0));

        for (int p = 0; p < PHASES; p++) begin
            write_identity((p == 0 || p == 4) ? 8'hff :
                           (p == 2) ? 8'h00 : 8'($urandom_range(1, 254)));
            send_request(make_req(apr_pkg::CMD_READ, 8'd0, 4'd0, 32'h0));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // some stretches run back to back with no idle cycles
                if (n % 32 == 0)
                    dense = ($urandom_range(0, 3) == 0);
                send_request(random_request());
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (failures == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
